// ===== rtl/core/multi_reader_broadcast_ring_assert.svh =====
// Assertion macros used by the broadcast ring controller.
`ifndef MULTI_READER_BROADCAST_RING_ASSERT_SVH
`define MULTI_READER_BROADCAST_RING_ASSERT_SVH
`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define MRBR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mrbr assertion failed");
// Check that cons holds in the clock cycle after ante.
`define MRBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrbr assertion failed");
`else
`define MRBR_ASSERT(lbl, clk, rst_n, prop)
`define MRBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/mrbr_pkg.sv =====
// Types, constants and codes of the broadcast ring.
package mrbr_pkg;

  // Ring depth must be a power of two: slot index is the low position bits.
  localparam int RingDepth  = 16;
  localparam int SlotBits   = $clog2(RingDepth);
  localparam int MaxReaders = 16;
  localparam int CountBits  = $clog2(MaxReaders + 1);
  localparam int WordBits   = 64;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActAdd   = 2'd2;

  localparam logic [1:0] StsOk    = 2'd0;
  localparam logic [1:0] StsBusy  = 2'd1;
  localparam logic [1:0] StsNack  = 2'd2;
  localparam logic [1:0] StsLimit = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] message_word;
    logic [31:0] reader_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_word;
    logic [31:0] next_position;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic result_valid;
  } dp_sts_t;

endpackage

// ===== rtl/core/mrbr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mrbr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mrbr_ctrl.sv =====
// Controller of the broadcast ring: capture and execute sequencing.
`include "multi_reader_broadcast_ring_assert.svh"
module mrbr_ctrl import mrbr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);

  localparam logic StateIdle = 1'b0;
  localparam logic StateExec = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    case (state_q)
      StateIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StateExec;
        end
      end
      StateExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StateIdle;
      end
      default: state_d = StateIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == StateExec);

  `MRBR_ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `MRBR_ASSERT_NEXT(a_exec_one_cycle, clk_i, rst_ni, busy_o, !busy_o)
  `MRBR_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, cmd_o.exec, sts_i.result_valid)
  `MRBR_ASSERT(a_result_only_after_exec, clk_i, rst_ni, !sts_i.result_valid || !busy_o)

endmodule

// ===== rtl/core/mrbr_dp.sv =====
// Datapath of the broadcast ring: slot store, counters and result register.
module mrbr_dp import mrbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_item_t  item_i,
  output dp_sts_t   sts_o,
  output out_item_t result_o
);

  in_item_t              item_q;
  logic [CountBits-1:0]  pending_q [RingDepth];
  logic [31:0]           write_index_q, write_index_d;
  logic [CountBits-1:0]  reader_total_q, reader_total_d;
  out_item_t             result_q, result_d;
  logic                  valid_q;

  logic [SlotBits-1:0]   raddr;
  logic [SlotBits-1:0]   slot;
  logic [CountBits-1:0]  pend;
  logic [WordBits-1:0]   rdata;
  logic                  ram_we;
  logic                  pend_we;
  logic [CountBits-1:0]  pend_wdata;

  // Word read is launched in the capture cycle from the incoming item.
  assign raddr = (item_i.action == ActRead) ? item_i.reader_position[SlotBits-1:0]
                                            : write_index_q[SlotBits-1:0];

  mrbr_ram #(
    .Width (WordBits),
    .Depth (RingDepth)
  ) u_words (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (item_q.message_word[WordBits-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign slot = (item_q.action == ActRead) ? item_q.reader_position[SlotBits-1:0]
                                           : write_index_q[SlotBits-1:0];
  assign pend = pending_q[slot];

  always_comb begin
    write_index_d  = write_index_q;
    reader_total_d = reader_total_q;
    ram_we         = 1'b0;
    pend_we        = 1'b0;
    pend_wdata     = pend;
    result_d       = '0;
    result_d.status = StsNack;
    case (item_q.action)
      ActWrite: begin
        if (pend != '0) begin
          result_d.status = StsBusy;
        end else begin
          result_d.status = StsOk;
          ram_we          = cmd_i.exec;
          pend_we         = cmd_i.exec;
          pend_wdata      = reader_total_q;
          write_index_d   = write_index_q + 32'd1;
        end
      end
      ActRead: begin
        if (pend != '0 && item_q.reader_position < write_index_q) begin
          result_d.status        = StsOk;
          result_d.read_word     = 64'(rdata);
          result_d.next_position = item_q.reader_position + 32'd1;
          pend_we                = cmd_i.exec;
          pend_wdata             = pend - CountBits'(1);
        end
      end
      ActAdd: begin
        result_d.next_position = write_index_q;
        if (reader_total_q >= CountBits'(MaxReaders)) begin
          result_d.status = StsLimit;
        end else begin
          result_d.status = StsOk;
          reader_total_d  = reader_total_q + CountBits'(1);
        end
      end
      default: result_d.status = StsNack;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_index_q  <= '0;
      reader_total_q <= '0;
      valid_q        <= 1'b0;
      for (int i = 0; i < RingDepth; i++) begin
        pending_q[i] <= '0;
      end
    end else begin
      valid_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        write_index_q  <= write_index_d;
        reader_total_q <= reader_total_d;
      end
      if (pend_we) begin
        pending_q[slot] <= pend_wdata;
      end
    end
  end

  assign sts_o.result_valid = valid_q;
  assign result_o           = result_q;

endmodule

// ===== rtl/core/multi_reader_broadcast_ring.sv =====
// Top level of the broadcast ring buffer with per-slot reader counts.
//
// Usage:
// - Input channel: present a transaction on in_i and raise start_i; it is
//   taken at the rising edge where start_i is high and busy_o is low.
//   in_i carries the action (write, read at position, add reader), the
//   message word and the reader position.
// - Result channel: every transaction yields exactly one result on result_o,
//   shown for one cycle with result_valid_o high. The receiver cannot stall
//   it, so sample it in that cycle.
// - Result timing: the result is registered at the end of the execute cycle.
// - Pacing: no new transaction is taken while busy_o is high. The slot word
//   store has a registered read port, so the capture cycle launches the read
//   and the execute cycle does the read-modify-write of the slot count; busy_o
//   is high during the execute cycle.
// - A new transaction may be accepted in the cycle its predecessor's result
//   is shown; the result register holds the two apart.
// - Reset: write index, reader count and all slot counts go to zero at once;
//   slot words are undefined until written, and no read can reach one that
//   was never written.
module multi_reader_broadcast_ring import mrbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  in_i,
  output logic      busy_o,
  output logic      result_valid_o,
  output out_item_t result_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence capture and execute; hold off new transactions while executing.
  mrbr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Hold the slot store, counters and the result register.
  mrbr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_i),
    .sts_o    (sts),
    .result_o (result_o)
  );

  assign result_valid_o = sts.result_valid;

endmodule
